// ----- hw/rtl/mclp_pkg.sv -----
// Package for the motor command line parser: character codes, parse phase and
// line kind types, field accumulator struct and the per-byte field helpers.
// No dependencies.
`default_nettype none

package mclp_pkg;

    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam int unsigned ACC_W   = 17;
    localparam int unsigned VAL_W   = 16;
    localparam int unsigned PROD_W  = ACC_W + 4;

    localparam logic [ACC_W-1:0] MAG_LIMIT = 17'd32768;
    localparam logic [ACC_W-1:0] NEG_BASE  = 17'h10000;
    localparam logic [VAL_W-1:0] POS_MAX   = 16'h7FFF;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_KIND   = 3'd1,
        PH_THIRD  = 3'd2,
        PH_LSTART = 3'd3,
        PH_LBODY  = 3'd4,
        PH_RSTART = 3'd5,
        PH_RBODY  = 3'd6,
        PH_WAIT   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_VEL     = 2'd0,
        KIND_PWM     = 2'd1,
        KIND_BATT    = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic             neg;
        logic             bad;
    } t_field;

    typedef struct packed {
        t_kind                   kind;
        logic signed [VAL_W-1:0] left;
        logic signed [VAL_W-1:0] right;
    } t_result;

    // Fold one byte into a field: leading sign, decimal digit, or a bad byte.
    function automatic t_field field_feed(t_field f, logic [7:0] b, logic first);
        t_field            r;
        logic [PROD_W-1:0] v;
        r = f;
        v = '0;
        if (first && (b == CH_MINUS || b == CH_PLUS)) begin
            r.neg = (b == CH_MINUS);
        end else if (b >= CH_0 && b <= CH_9) begin
            v = ({4'b0, f.acc} << 3) + ({4'b0, f.acc} << 1) + {17'b0, b[3:0]};
            r.acc = (v > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : v[ACC_W-1:0];
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    // Signed, saturated value of a finished field; a malformed field reads 0.
    function automatic logic signed [VAL_W-1:0] field_value(t_field f);
        logic [ACC_W-1:0] d;
        d = NEG_BASE - f.acc;
        if (f.bad) begin
            return '0;
        end else if (f.neg) begin
            return d[VAL_W-1:0];
        end else if (f.acc > {1'b0, POS_MAX}) begin
            return POS_MAX;
        end
        return f.acc[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/motor_command_line_parser.sv -----
// Motor command line parser. One received byte per beat goes into an input
// register, is parsed in a single step and any finished command lands in an
// output register. The block sustains one byte per cycle; o_valid for a result
// rises when its newline beat has gone via the input register and the parse
// into the output register; only a stalled output register holds up input.
// Lines "MV?l;r" / "MP?l;r" give velocity or PWM commands with saturated
// 16-bit values (0 for a malformed field); a 'B' line gives a battery query.
// Depends on mclp_pkg, mclp_parser.
`default_nettype none

module motor_command_line_parser
    import mclp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_command_kind,
    output logic signed [15:0]     o_left_value,
    output logic signed [15:0]     o_right_value
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       step;
    logic       emit;
    t_result    result;

    // the pipeline moves whenever the output register is free or being drained
    assign advance = !r_out_valid || i_ready;
    assign step    = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    mclp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command_kind = r_out.kind;
    assign o_left_value   = r_out.left;
    assign o_right_value  = r_out.right;

`ifndef SYNTH
    a_emit_on_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (step && r_in_byte == CH_NL))
        else $error("result raised on a byte that is not a newline");

    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_command_kind != KIND_UNKNOWN))
        else $error("unknown line kind reported");

    a_batt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_command_kind == KIND_BATT) |->
            (o_left_value == 16'sd0 && o_right_value == 16'sd0))
        else $error("battery query with nonzero values");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a byte while stalled");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/mclp_parser.sv -----
// Line parser core: phase, line kind and field state, advanced one byte per step.
// Depends on mclp_pkg.
`default_nettype none

module mclp_parser
    import mclp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_emit,
    output t_result         o_result
);

    t_phase r_phase, n_phase;
    t_kind  r_kind,  n_kind;
    t_field r_left,  n_left;
    t_field r_right, n_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= KIND_VEL;
            r_left  <= '0;
            r_right <= '0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_kind   = r_kind;
        n_left   = r_left;
        n_right  = r_right;
        o_emit   = 1'b0;
        o_result = '0;
        if (i_step) begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_left  = '0;
                    n_right = '0;
                    if (i_byte == CH_NL) begin
                        n_phase = PH_IDLE;
                    end else if (i_byte == CH_M) begin
                        n_phase = PH_KIND;
                    end else if (i_byte == CH_B) begin
                        n_kind  = KIND_BATT;
                        n_phase = PH_WAIT;
                    end else begin
                        n_kind  = KIND_UNKNOWN;
                        n_phase = PH_WAIT;
                    end
                end
                PH_KIND: begin
                    if (i_byte == CH_NL) begin
                        n_phase = PH_IDLE;
                    end else if (i_byte == CH_V) begin
                        n_kind  = KIND_VEL;
                        n_phase = PH_THIRD;
                    end else if (i_byte == CH_P) begin
                        n_kind  = KIND_PWM;
                        n_phase = PH_THIRD;
                    end else begin
                        n_kind  = KIND_UNKNOWN;
                        n_phase = PH_WAIT;
                    end
                end
                PH_THIRD: begin
                    n_phase = (i_byte == CH_NL) ? PH_IDLE : PH_LSTART;
                end
                PH_LSTART, PH_LBODY: begin
                    if (i_byte == CH_NL) begin
                        n_phase = PH_IDLE;
                    end else if (i_byte == CH_SEMI) begin
                        n_phase = PH_RSTART;
                    end else begin
                        n_left  = field_feed(r_left, i_byte, r_phase == PH_LSTART);
                        n_phase = PH_LBODY;
                    end
                end
                PH_RSTART, PH_RBODY: begin
                    if (i_byte == CH_NL) begin
                        o_emit         = 1'b1;
                        o_result.kind  = r_kind;
                        o_result.left  = field_value(r_left);
                        o_result.right = field_value(r_right);
                        n_phase        = PH_IDLE;
                    end else begin
                        n_right = field_feed(r_right, i_byte, r_phase == PH_RSTART);
                        n_phase = PH_RBODY;
                    end
                end
                PH_WAIT: begin
                    if (i_byte == CH_NL) begin
                        // only a battery line reports; unknown lines drop silently
                        if (r_kind == KIND_BATT) begin
                            o_emit        = 1'b1;
                            o_result.kind = KIND_BATT;
                        end
                        n_phase = PH_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire
